>>> rtl/wsd_pkg.sv
// wsd_pkg: shared types and constants for the WebSocket frame deframer.
// No dependencies; used by rtl/websocket_frame_deframer.sv.

package wsd_pkg;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_FIRST   = 6'b000001,
        PH_SECOND  = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // 7-bit length codes that select an extended length field
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Byte counts of the extended length and key fields (modulo 8)
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    localparam int LEN_W     = 64;
    localparam int FRM_LEN_W = 63;
    localparam int KEY_W     = 32;

endpackage

>>> rtl/websocket_frame_deframer.sv
// websocket_frame_deframer: RFC 6455 receive-side frame parser and unmasker.
// Depends on rtl/wsd_pkg.sv.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | in_byte
//  out     | output    | out_valid / out_ready| kind fin_flag op_code mask_flag
//          |           |                      | frame_length out_byte last
//
// One byte per cycle while the output is not stalled. A byte goes to an input register, is
// parsed in the next cycle against the frame state, and any result lands in the output
// register; out_valid rises when that register is loaded from the input register.
// in_ready stays high while the output register is empty or is being taken; a stalled
// output holds one byte in the input register.
// rst_n (asynchronous) returns the parser to the first header byte; no clearing pass.

module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic        fin_flag,
    output logic [3:0]  op_code,
    output logic        mask_flag,
    output logic [62:0] frame_length,
    output logic [7:0]  out_byte,
    output logic        last
);

    // Input register
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;

    // Frame state
    wsd_pkg::phase_t               phase_reg, phase_next;
    logic                          fin_reg, fin_next;
    logic [3:0]                    opcode_reg, opcode_next;
    logic                          mask_reg, mask_next;
    logic [wsd_pkg::LEN_W-1:0]     length_reg, length_next;
    logic [2:0]                    hdr_cnt_reg, hdr_cnt_next;
    logic [wsd_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [wsd_pkg::LEN_W-1:0]     remain_reg, remain_next;
    logic [1:0]                    key_idx_reg, key_idx_next;

    // Output register
    logic        out_valid_reg;
    logic        kind_reg;
    logic        fin_out_reg;
    logic [3:0]  opcode_out_reg;
    logic        mask_out_reg;
    logic [62:0] frame_length_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;

    // Stage results
    logic        advance;
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic        res_last;
    logic        hdr_done;
    logic        len_done;
    logic [2:0]  cnt_inc;
    logic [7:0]  key_byte;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !stage_valid_reg || advance;
    assign cnt_inc  = hdr_cnt_reg + 3'd1;

    // Key byte for the current payload position, first key byte is the top byte
    always_comb
    begin
        unique case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Parser: next frame state and result for the byte in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        length_next  = length_reg;
        hdr_cnt_next = hdr_cnt_reg;
        key_next     = key_reg;
        remain_next  = remain_reg;
        key_idx_next = key_idx_reg;
        res_valid    = 1'b0;
        res_kind     = wsd_pkg::KIND_HEADER;
        res_byte     = 8'd0;
        res_last     = 1'b0;
        len_done     = 1'b0;
        hdr_done     = 1'b0;

        unique case (phase_reg)
            wsd_pkg::PH_SECOND:
            begin
                mask_next    = stage_byte_reg[7];
                hdr_cnt_next = 3'd0;
                if (stage_byte_reg[6:0] == wsd_pkg::LEN_CODE_EXT16)
                begin
                    length_next = '0;
                    phase_next  = wsd_pkg::PH_EXT16;
                end
                else if (stage_byte_reg[6:0] == wsd_pkg::LEN_CODE_EXT64)
                begin
                    length_next = '0;
                    phase_next  = wsd_pkg::PH_EXT64;
                end
                else
                begin
                    length_next = {57'd0, stage_byte_reg[6:0]};
                    len_done    = 1'b1;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                length_next  = {length_reg[55:0], stage_byte_reg};
                hdr_cnt_next = cnt_inc;
                if (phase_reg == wsd_pkg::PH_EXT16)
                    len_done = (cnt_inc == wsd_pkg::EXT16_BYTES);
                else
                    len_done = (cnt_inc == wsd_pkg::EXT64_BYTES);
            end
            wsd_pkg::PH_KEY:
            begin
                key_next     = {key_reg[23:0], stage_byte_reg};
                hdr_cnt_next = cnt_inc;
                hdr_done     = (cnt_inc == wsd_pkg::KEY_BYTES);
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                res_valid    = 1'b1;
                res_kind     = wsd_pkg::KIND_PAYLOAD;
                res_byte     = stage_byte_reg ^ key_byte;
                res_last     = (remain_reg == 64'd1);
                remain_next  = remain_reg - 64'd1;
                key_idx_next = key_idx_reg + 2'd1;
                if (res_last)
                    phase_next = wsd_pkg::PH_FIRST;
            end
            default:
            begin
                // first header byte: FIN and opcode, clear mask, length, key and header count
                fin_next     = stage_byte_reg[7];
                opcode_next  = stage_byte_reg[3:0];
                mask_next    = 1'b0;
                length_next  = '0;
                key_next     = '0;
                hdr_cnt_next = 3'd0;
                phase_next   = wsd_pkg::PH_SECOND;
            end
        endcase

        // Length complete: read the key if masked, else the header is done
        if (len_done)
        begin
            hdr_cnt_next = 3'd0;
            if (mask_next)
                phase_next = wsd_pkg::PH_KEY;
            else
                hdr_done = 1'b1;
        end

        // Header complete: emit the summary
        if (hdr_done)
        begin
            hdr_cnt_next = 3'd0;
            key_idx_next = 2'd0;
            remain_next  = length_next;
            res_valid    = 1'b1;
            res_last     = (length_next == '0);
            phase_next   = res_last ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_byte_reg <= in_byte;
    end

    // Frame state, updated when the staged byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wsd_pkg::PH_FIRST;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            mask_reg    <= 1'b0;
            length_reg  <= '0;
            hdr_cnt_reg <= 3'd0;
            key_reg     <= '0;
            remain_reg  <= '0;
            key_idx_reg <= 2'd0;
        end
        else if (stage_valid_reg && advance)
        begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            length_reg  <= length_next;
            hdr_cnt_reg <= hdr_cnt_next;
            key_reg     <= key_next;
            remain_reg  <= remain_next;
            key_idx_reg <= key_idx_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid_reg && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg && res_valid)
        begin
            kind_reg         <= res_kind;
            fin_out_reg      <= fin_next;
            opcode_out_reg   <= opcode_next;
            mask_out_reg     <= mask_next;
            frame_length_reg <= length_next[wsd_pkg::FRM_LEN_W-1:0];
            out_byte_reg     <= res_byte;
            last_reg         <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign fin_flag     = fin_out_reg;
    assign op_code      = opcode_out_reg;
    assign mask_flag    = mask_out_reg;
    assign frame_length = frame_length_reg;
    assign out_byte     = out_byte_reg;
    assign last         = last_reg;

    // Checks
    a_hdr_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == wsd_pkg::KIND_HEADER) |-> out_byte == 8'd0)
        else $error("header summary carries a nonzero byte");

    a_empty_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == wsd_pkg::KIND_HEADER) && last |-> frame_length == '0)
        else $error("last header summary with nonzero length");

    a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsd_pkg::PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_key_unmasked: assert property (@(posedge clk) disable iff (!rst_n)
        !mask_reg && (phase_reg != wsd_pkg::PH_FIRST) |-> key_reg == '0)
        else $error("key loaded for an unmasked frame");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && out_valid_reg && !out_ready |=> stage_valid_reg
            && $stable(phase_reg))
        else $error("parser advanced while output stalled");

endmodule

>>> tb/sv/websocket_frame_deframer_test.sv
// Self-checking testbench for websocket_frame_deframer: byte stream in, header summaries
// and unmasked payload bytes out. Depends on rtl/wsd_pkg.sv and rtl/websocket_frame_deframer.sv.
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

    // One output item, in port order
    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [3:0]  op;
        logic        mask;
        logic [62:0] len;
        logic [7:0]  data;
        logic        last;
    } result_t;

    // One row of the directed table; res is used only when fixed is set
    typedef struct packed {
        logic [7:0] val;
        logic       fixed;
        result_t    res;
    } step_t;

    localparam result_t NO_RESULT = '0;
    localparam int LONG_STALL_CYCLES = 200;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic        fin_flag;
    logic [3:0]  op_code;
    logic        mask_flag;
    logic [62:0] frame_length;
    logic [7:0]  out_byte;
    logic        last;

    websocket_frame_deframer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .fin_flag     (fin_flag),
        .op_code      (op_code),
        .mask_flag    (mask_flag),
        .frame_length (frame_length),
        .out_byte     (out_byte),
        .last         (last)
    );

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Frame parser state of the predictor
    wsd_pkg::phase_t ph_q = wsd_pkg::PH_FIRST;
    logic        fin_q = 1'b0;
    logic [3:0]  op_q = 4'h0;
    logic        mask_q = 1'b0;
    logic [63:0] len_q = '0;
    logic [2:0]  cnt_q = '0;
    logic [31:0] key_q = '0;
    logic [63:0] idx_q = '0;

    result_t     pending_results [$];
    step_t       directed [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        long_stall_req = 1'b0;
    logic        long_stall_done = 1'b0;
    int          stall_left = 0;

    int          mismatches = 0;
    int          items_sent = 0;
    int          frames_sent = 0;
    int          headers_seen = 0;
    int          payload_seen = 0;
    result_t     seen;
    result_t     want;

    function automatic result_t frame_res(logic k, logic f, logic [3:0] o, logic m,
                                          logic [62:0] l, logic [7:0] d, logic lst);
        return {k, f, o, m, l, d, lst};
    endfunction

    // Advance the parser by one stream byte; got is set when a result comes out
    task automatic deframe(input logic [7:0] b, output bit got, output result_t r);
        bit       len_done;
        bit       hdr_done;
        bit       is_last;
        logic [7:0] k;
        got = 0;
        r = NO_RESULT;
        len_done = 0;
        hdr_done = 0;
        case (ph_q)
            wsd_pkg::PH_SECOND:
            begin
                mask_q = b[7];
                cnt_q = '0;
                if (b[6:0] == wsd_pkg::LEN_CODE_EXT16)
                begin
                    len_q = '0;
                    ph_q = wsd_pkg::PH_EXT16;
                end
                else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64)
                begin
                    len_q = '0;
                    ph_q = wsd_pkg::PH_EXT64;
                end
                else
                begin
                    len_q = {57'd0, b[6:0]};
                    len_done = 1;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                len_q = {len_q[55:0], b};
                cnt_q = cnt_q + 3'd1;
                if (cnt_q == ((ph_q == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_BYTES
                                                          : wsd_pkg::EXT64_BYTES))
                    len_done = 1;
            end
            wsd_pkg::PH_KEY:
            begin
                key_q = {key_q[23:0], b};
                cnt_q = cnt_q + 3'd1;
                if (cnt_q == wsd_pkg::KEY_BYTES)
                    hdr_done = 1;
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                k = key_q[8 * (3 - idx_q[1:0]) +: 8];
                idx_q = idx_q + 64'd1;
                is_last = (idx_q == len_q);
                got = 1;
                r = frame_res(wsd_pkg::KIND_PAYLOAD, fin_q, op_q, mask_q, len_q[62:0],
                              b ^ k, is_last);
                if (is_last)
                    ph_q = wsd_pkg::PH_FIRST;
            end
            default:
            begin
                // first header byte, also the landing spot for any odd phase
                fin_q = b[7];
                op_q = b[3:0];
                mask_q = 1'b0;
                len_q = '0;
                key_q = '0;
                idx_q = '0;
                cnt_q = '0;
                ph_q = wsd_pkg::PH_SECOND;
            end
        endcase

        // length known: key follows only when masked
        if (len_done)
        begin
            cnt_q = '0;
            if (mask_q)
                ph_q = wsd_pkg::PH_KEY;
            else
                hdr_done = 1;
        end

        // header complete: summary item
        if (hdr_done)
        begin
            idx_q = '0;
            cnt_q = '0;
            got = 1;
            r = frame_res(wsd_pkg::KIND_HEADER, fin_q, op_q, mask_q, len_q[62:0], 8'h00,
                          len_q == 0);
            ph_q = (len_q == 0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
        end
    endtask

    // Offer one byte, hold it until accepted, then queue what it should produce
    task automatic send_byte(input logic [7:0] b, input logic fixed, input result_t fixed_res);
        bit      got;
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        deframe(b, got, r);
        if (fixed)
            pending_results.push_back(fixed_res);
        else if (got)
            pending_results.push_back(r);
    endtask

    // Well-formed frame with random header fields, length form, key and payload
    task automatic send_random_frame();
        logic [7:0]  frame [$];
        logic [63:0] plen;
        logic        masked;
        int          sel;
        masked = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        frame.push_back(8'($urandom_range(0, 255)));
        if (sel < 70)
        begin
            plen = 64'((sel < 55) ? $urandom_range(0, 12) : $urandom_range(13, 125));
            frame.push_back({masked, plen[6:0]});
        end
        else if (sel < 90)
        begin
            plen = 64'((sel < 85) ? $urandom_range(0, 40) : $urandom_range(126, 700));
            frame.push_back({masked, wsd_pkg::LEN_CODE_EXT16});
            frame.push_back(plen[15:8]);
            frame.push_back(plen[7:0]);
        end
        else
        begin
            plen = 64'($urandom_range(0, 30));
            frame.push_back({masked, wsd_pkg::LEN_CODE_EXT64});
            for (int i = 7; i >= 0; i--)
                frame.push_back(plen[8 * i +: 8]);
        end
        if (masked)
            repeat (4) frame.push_back(8'($urandom_range(0, 255)));
        repeat (plen) frame.push_back(8'($urandom_range(0, 255)));
        foreach (frame[i])
            send_byte(frame[i], 1'b0, NO_RESULT);
        frames_sent++;
    endtask

    task automatic run_random(input int s_pct, input int r_pct, input int n_items);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_frame();
    endtask

    // Receiver: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (long_stall_req && !long_stall_done)
        begin
            out_ready <= 1'b0;
            stall_left <= LONG_STALL_CYCLES;
            long_stall_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = {kind, fin_flag, op_code, mask_flag, frame_length, out_byte, last};
            if (seen.kind == wsd_pkg::KIND_HEADER)
                headers_seen++;
            else
                payload_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected item kind %0d byte %02h len %0d last %0d",
                             $realtime, seen.kind, seen.data, seen.len, seen.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind || seen.fin !== want.fin || seen.op !== want.op ||
                    seen.mask !== want.mask || seen.len !== want.len ||
                    seen.data !== want.data || seen.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch exp kind %0d fin %0d op %h mask %0d len %0d",
                                 $realtime, want.kind, want.fin, want.op, want.mask, want.len);
                        $display("    byte %02h last %0d / got kind %0d fin %0d op %h mask %0d",
                                 want.data, want.last, seen.kind, seen.fin, seen.op, seen.mask);
                        $display("    len %0d byte %02h last %0d",
                                 seen.len, seen.data, seen.last);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout with %0d expected items outstanding", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        // zero-length unmasked text frame, final
        directed.push_back({8'h81, 1'b0, NO_RESULT});
        directed.push_back({8'h00, 1'b1,
                            frame_res(wsd_pkg::KIND_HEADER, 1'b1, 4'hF & 4'h1, 1'b0, 63'd0,
                                      8'h00, 1'b1)});
        // 16-bit length of zero, opcode 15, not final
        directed.push_back({8'h0F, 1'b0, NO_RESULT});
        directed.push_back({8'h7E, 1'b0, NO_RESULT});
        directed.push_back({8'h00, 1'b0, NO_RESULT});
        directed.push_back({8'h00, 1'b1,
                            frame_res(wsd_pkg::KIND_HEADER, 1'b0, 4'hF, 1'b0, 63'd0,
                                      8'h00, 1'b1)});
        // masked two-byte close frame with RSV bits set
        directed.push_back({8'hF8, 1'b0, NO_RESULT});
        directed.push_back({8'h82, 1'b0, NO_RESULT});
        directed.push_back({8'hFF, 1'b0, NO_RESULT});
        directed.push_back({8'h00, 1'b0, NO_RESULT});
        directed.push_back({8'hA5, 1'b0, NO_RESULT});
        directed.push_back({8'h5A, 1'b1,
                            frame_res(wsd_pkg::KIND_HEADER, 1'b1, 4'h8, 1'b1, 63'd2,
                                      8'h00, 1'b0)});
        directed.push_back({8'hFF, 1'b1,
                            frame_res(wsd_pkg::KIND_PAYLOAD, 1'b1, 4'h8, 1'b1, 63'd2,
                                      8'h00, 1'b0)});
        directed.push_back({8'h3C, 1'b1,
                            frame_res(wsd_pkg::KIND_PAYLOAD, 1'b1, 4'h8, 1'b1, 63'd2,
                                      8'h3C, 1'b1)});
        // ping with a non-minimal 64-bit length of one
        directed.push_back({8'h89, 1'b0, NO_RESULT});
        directed.push_back({8'h7F, 1'b0, NO_RESULT});
        repeat (7) directed.push_back({8'h00, 1'b0, NO_RESULT});
        directed.push_back({8'h01, 1'b1,
                            frame_res(wsd_pkg::KIND_HEADER, 1'b1, 4'h9, 1'b0, 63'd1,
                                      8'h00, 1'b0)});
        directed.push_back({8'hAB, 1'b1,
                            frame_res(wsd_pkg::KIND_PAYLOAD, 1'b1, 4'h9, 1'b0, 63'd1,
                                      8'hAB, 1'b1)});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        send_idle_pct = 21;
        recv_idle_pct = 66;
        foreach (directed[i])
            send_byte(directed[i].val, directed[i].fixed, directed[i].res);

        // random frames under three idle mixes; long output hold-off in the last
        run_random(21, 66, 450);
        run_random(66, 21, 450);
        long_stall_req <= 1'b1;
        run_random(0, 0, 450);

        // length with the top bit set: reported length drops it, payload never ends
        send_byte(8'h80 | 8'($urandom_range(0, 15)), 1'b0, NO_RESULT);
        send_byte({1'b1, wsd_pkg::LEN_CODE_EXT64}, 1'b0, NO_RESULT);
        send_byte(8'h80, 1'b0, NO_RESULT);
        repeat (7) send_byte(8'h00, 1'b0, NO_RESULT);
        repeat (34) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stream bytes in %0d random frames plus directed cases;",
                 items_sent, frames_sent);
        $display("checked %0d header summaries and %0d payload bytes, %0d mismatches",
                 headers_seen, payload_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
